// File: rtl/imj_pkg.sv
// shared types, codes and field widths of the id-list merge join engine
package imj_pkg;

    localparam int LIST_DEPTH_DEF    = 32;
    localparam int SEQ_ID_BITS_DEF   = 16;
    localparam int EVENT_ID_BITS_DEF = 8;

    localparam int OPC_W    = 2;
    localparam int SEQ_W    = 16;
    localparam int EV_W     = 8;
    localparam int SUP_W    = 6;
    localparam int MINSUP_W = 16;

    localparam logic [OPC_W-1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [OPC_W-1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [OPC_W-1:0] OP_JOIN_EQ     = 2'd2;
    localparam logic [OPC_W-1:0] OP_JOIN_TEMP   = 2'd3;

    localparam logic KIND_PAIR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [MINSUP_W-1:0] THRESHOLD_RST = 16'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MERGE,
        ST_SCAN_I,
        ST_SCAN_J,
        ST_PAIR_T,
        ST_PAIR_E,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

    typedef struct packed {
        logic                valid;
        logic                kind;
        logic [SEQ_W-1:0]    seq;
        logic [EV_W-1:0]     ev;
        logic [SUP_W-1:0]    support;
        logic                frequent;
        logic                overflowed;
        logic                last;
    } emit_t;

endpackage

// File: rtl/idlist_merge_join.sv
// top level of the id-list merge join engine
// a load transaction is accepted in the idle state; the engine is ready again the next cycle
// a run stalls the input through the start step, the merge walk and block scans, the pair
// examination in each matching block and the summary, and is lengthened while the output
// register is held
// reset (async, active low) empties both lists, clears overflow and sets the threshold to 1
module idlist_merge_join #(
    parameter int LIST_DEPTH    = imj_pkg::LIST_DEPTH_DEF,
    parameter int SEQ_ID_BITS   = imj_pkg::SEQ_ID_BITS_DEF,
    parameter int EVENT_ID_BITS = imj_pkg::EVENT_ID_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // seq_id[15:0], event_id[23:16]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_seq_id, out_event_id, support, frequent, overflowed
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    import imj_pkg::*;

    localparam int AW    = $clog2(LIST_DEPTH);
    localparam int DW    = SEQ_ID_BITS + EVENT_ID_BITS;
    localparam int CMP_W = (SEQ_ID_BITS > EVENT_ID_BITS) ? SEQ_ID_BITS : EVENT_ID_BITS;

    logic              we1, we2;
    logic [AW-1:0]     waddr, raddr1, raddr2;
    logic [DW-1:0]     wdata, rdata1, rdata2;
    logic [CMP_W-1:0]  cmp_a, cmp_b;
    cmp_res_t          cmp_res;
    emit_t             emit;
    logic              out_ready;

    logic              m_valid_reg;
    logic [31:0]       m_data_reg;
    logic              m_kind_reg;
    logic              m_last_reg;

    imj_list_ram #(.DEPTH(LIST_DEPTH), .WIDTH(DW)) u_first_ram (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr1),
        .rdata (rdata1)
    );

    imj_list_ram #(.DEPTH(LIST_DEPTH), .WIDTH(DW)) u_second_ram (
        .clk   (clk),
        .we    (we2),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr2),
        .rdata (rdata2)
    );

    imj_cmp_unit #(.W(CMP_W)) u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    imj_ctrl #(
        .LIST_DEPTH    (LIST_DEPTH),
        .SEQ_ID_BITS   (SEQ_ID_BITS),
        .EVENT_ID_BITS (EVENT_ID_BITS),
        .AW            (AW),
        .DW            (DW),
        .CMP_W         (CMP_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .opcode    (s_axis_tuser),
        .seq_in    (s_axis_tdata[15:0]),
        .ev_in     (s_axis_tdata[23:16]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .we1       (we1),
        .we2       (we2),
        .waddr     (waddr),
        .wdata     (wdata),
        .raddr1    (raddr1),
        .raddr2    (raddr2),
        .rdata1    (rdata1),
        .rdata2    (rdata2),
        .cmp_a     (cmp_a),
        .cmp_b     (cmp_b),
        .cmp_res   (cmp_res),
        .out_ready (out_ready),
        .emit      (emit)
    );

    assign out_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            m_data_reg <= {emit.overflowed, emit.frequent, emit.support, emit.ev, emit.seq};
            m_kind_reg <= emit.kind;
            m_last_reg <= emit.last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

// File: rtl/imj_list_ram.sv
// single-port-write, registered-read id-list storage
module imj_list_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/imj_cmp_unit.sv
// shared magnitude and equality comparator
module imj_cmp_unit #(
    parameter int W = 16
) (
    input  logic [W-1:0]       a,
    input  logic [W-1:0]       b,
    output imj_pkg::cmp_res_t  res
);

    import imj_pkg::*;

    always_comb
    begin
        res.lt = (a < b);
        res.eq = (a == b);
    end

endmodule

// File: rtl/imj_ctrl.sv
// sequencer: list loading, merge walk, block scans, pair joins and summary
module imj_ctrl #(
    parameter int LIST_DEPTH    = imj_pkg::LIST_DEPTH_DEF,
    parameter int SEQ_ID_BITS   = imj_pkg::SEQ_ID_BITS_DEF,
    parameter int EVENT_ID_BITS = imj_pkg::EVENT_ID_BITS_DEF,
    parameter int AW            = $clog2(LIST_DEPTH),
    parameter int DW            = SEQ_ID_BITS + EVENT_ID_BITS,
    parameter int CMP_W         = (SEQ_ID_BITS > EVENT_ID_BITS) ? SEQ_ID_BITS : EVENT_ID_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [imj_pkg::OPC_W-1:0]      opcode,
    input  logic [imj_pkg::SEQ_W-1:0]      seq_in,
    input  logic [imj_pkg::EV_W-1:0]       ev_in,
    input  logic                           cfg_we,
    input  logic [imj_pkg::MINSUP_W-1:0]   cfg_wdata,
    output logic                           we1,
    output logic                           we2,
    output logic [AW-1:0]                  waddr,
    output logic [DW-1:0]                  wdata,
    output logic [AW-1:0]                  raddr1,
    output logic [AW-1:0]                  raddr2,
    input  logic [DW-1:0]                  rdata1,
    input  logic [DW-1:0]                  rdata2,
    output logic [CMP_W-1:0]               cmp_a,
    output logic [CMP_W-1:0]               cmp_b,
    input  imj_pkg::cmp_res_t              cmp_res,
    input  logic                           out_ready,
    output imj_pkg::emit_t                 emit
);

    import imj_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    state_t                   state_reg, state_next;
    logic [CW-1:0]            fc_reg, fc_next;
    logic [CW-1:0]            sc_reg, sc_next;
    logic                     ovf_reg, ovf_next;
    logic [CW-1:0]            i_reg, i_next;
    logic [CW-1:0]            j_reg, j_next;
    logic [CW-1:0]            x_reg, x_next;
    logic [CW-1:0]            y_reg, y_next;
    logic [CW-1:0]            si_reg, si_next;
    logic [CW-1:0]            sj_reg, sj_next;
    logic [SEQ_ID_BITS-1:0]   seq_reg, seq_next;
    logic [EVENT_ID_BITS-1:0] t0_reg, t0_next;
    logic                     temporal_reg, temporal_next;
    logic [CW-1:0]            en_reg, en_next;
    logic [CW-1:0]            sup_reg, sup_next;
    logic [SEQ_ID_BITS-1:0]   last_seq_reg, last_seq_next;
    logic [MINSUP_W-1:0]      min_sup_reg;

    logic [SEQ_ID_BITS-1:0]   rd1_seq, rd2_seq;
    logic [EVENT_ID_BITS-1:0] rd1_ev, rd2_ev;
    logic                     hit;
    logic                     want;

    assign rd1_seq = rdata1[SEQ_ID_BITS-1:0];
    assign rd1_ev  = rdata1[DW-1:SEQ_ID_BITS];
    assign rd2_seq = rdata2[SEQ_ID_BITS-1:0];
    assign rd2_ev  = rdata2[DW-1:SEQ_ID_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fc_reg       <= '0;
            sc_reg       <= '0;
            ovf_reg      <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            si_reg       <= '0;
            sj_reg       <= '0;
            temporal_reg <= 1'b0;
            en_reg       <= '0;
            sup_reg      <= '0;
            last_seq_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            fc_reg       <= fc_next;
            sc_reg       <= sc_next;
            ovf_reg      <= ovf_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            si_reg       <= si_next;
            sj_reg       <= sj_next;
            temporal_reg <= temporal_next;
            en_reg       <= en_next;
            sup_reg      <= sup_next;
            last_seq_reg <= last_seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
        t0_reg  <= t0_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sup_reg <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            min_sup_reg <= cfg_wdata;
        end
    end

    // comparator operand select
    always_comb
    begin
        cmp_a = '0;
        cmp_b = '0;
        case (state_reg)
            ST_MERGE:
            begin
                cmp_a = CMP_W'(rd1_seq);
                cmp_b = CMP_W'(rd2_seq);
            end
            ST_SCAN_I:
            begin
                cmp_a = CMP_W'(rd1_seq);
                cmp_b = CMP_W'(seq_reg);
            end
            ST_SCAN_J:
            begin
                cmp_a = CMP_W'(rd2_seq);
                cmp_b = CMP_W'(seq_reg);
            end
            ST_PAIR_T:
            begin
                cmp_a = CMP_W'(t0_reg);
                cmp_b = CMP_W'(rd2_ev);
            end
            ST_PAIR_E:
            begin
                cmp_a = CMP_W'(rd1_ev);
                cmp_b = CMP_W'(rd2_ev);
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign hit  = (state_reg == ST_PAIR_T) ? cmp_res.lt : cmp_res.eq;
    assign want = hit && (en_reg < DEPTH_C);

    always_comb
    begin
        state_next    = state_reg;
        fc_next       = fc_reg;
        sc_next       = sc_reg;
        ovf_next      = ovf_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        si_next       = si_reg;
        sj_next       = sj_reg;
        seq_next      = seq_reg;
        t0_next       = t0_reg;
        temporal_next = temporal_reg;
        en_next       = en_reg;
        sup_next      = sup_reg;
        last_seq_next = last_seq_reg;

        s_ready = (state_reg == ST_IDLE);
        we1     = 1'b0;
        we2     = 1'b0;
        waddr   = fc_reg[AW-1:0];
        wdata   = {EVENT_ID_BITS'(ev_in), SEQ_ID_BITS'(seq_in)};
        emit    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    case (opcode)
                        OP_LOAD_FIRST:
                        begin
                            if (fc_reg < DEPTH_C)
                            begin
                                we1     = 1'b1;
                                waddr   = fc_reg[AW-1:0];
                                fc_next = fc_reg + CW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_LOAD_SECOND:
                        begin
                            if (sc_reg < DEPTH_C)
                            begin
                                we2     = 1'b1;
                                waddr   = sc_reg[AW-1:0];
                                sc_next = sc_reg + CW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_JOIN_EQ, OP_JOIN_TEMP:
                        begin
                            temporal_next = (opcode == OP_JOIN_TEMP);
                            i_next        = '0;
                            j_next        = '0;
                            en_next       = '0;
                            sup_next      = '0;
                            last_seq_next = '0;
                            state_next    = ST_START;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_START:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if ((i_reg < fc_reg) && (j_reg < sc_reg))
                begin
                    if (cmp_res.lt)
                    begin
                        i_next = i_reg + CW'(1);
                    end
                    else if (cmp_res.eq)
                    begin
                        si_next    = i_reg;
                        sj_next    = j_reg;
                        seq_next   = rd1_seq;
                        t0_next    = rd1_ev;
                        i_next     = i_reg + CW'(1);
                        j_next     = j_reg + CW'(1);
                        state_next = ST_SCAN_I;
                    end
                    else
                    begin
                        j_next = j_reg + CW'(1);
                    end
                end
                else
                begin
                    state_next = ST_SUMMARY;
                end
            end
            ST_SCAN_I:
            begin
                if ((i_reg < fc_reg) && cmp_res.eq)
                begin
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_SCAN_J;
                end
            end
            ST_SCAN_J:
            begin
                if ((j_reg < sc_reg) && cmp_res.eq)
                begin
                    j_next = j_reg + CW'(1);
                end
                else
                begin
                    x_next     = si_reg;
                    y_next     = sj_reg;
                    state_next = temporal_reg ? ST_PAIR_T : ST_PAIR_E;
                end
            end
            ST_PAIR_T, ST_PAIR_E:
            begin
                if (!want || out_ready)
                begin
                    if (want)
                    begin
                        emit.valid = 1'b1;
                        emit.kind  = KIND_PAIR;
                        emit.seq   = SEQ_W'(seq_reg);
                        emit.ev    = EV_W'(rd2_ev);
                        en_next    = en_reg + CW'(1);
                        if ((en_reg == '0) || (last_seq_reg != seq_reg))
                        begin
                            sup_next = sup_reg + CW'(1);
                        end
                        last_seq_next = seq_reg;
                    end
                    if ((y_reg + CW'(1)) != j_reg)
                    begin
                        y_next = y_reg + CW'(1);
                    end
                    else if ((state_reg == ST_PAIR_E) && ((x_reg + CW'(1)) != i_reg))
                    begin
                        x_next = x_reg + CW'(1);
                        y_next = sj_reg;
                    end
                    else
                    begin
                        state_next = ST_MERGE;
                    end
                end
            end
            ST_SUMMARY:
            begin
                if (out_ready)
                begin
                    emit.valid      = 1'b1;
                    emit.kind       = KIND_SUMMARY;
                    emit.support    = SUP_W'(sup_reg);
                    emit.frequent   = (MINSUP_W'(sup_reg) >= min_sup_reg);
                    emit.overflowed = ovf_reg;
                    emit.last       = 1'b1;
                    fc_next         = '0;
                    sc_next         = '0;
                    ovf_next        = 1'b0;
                    i_next          = '0;
                    j_next          = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read addresses follow the pointer the next state will look at
    assign raddr1 = (state_next == ST_PAIR_E) ? x_next[AW-1:0] : i_next[AW-1:0];
    assign raddr2 = ((state_next == ST_PAIR_E) || (state_next == ST_PAIR_T)) ?
                    y_next[AW-1:0] : j_next[AW-1:0];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fc_reg <= DEPTH_C) && (sc_reg <= DEPTH_C) && (en_reg <= DEPTH_C)
        && (sup_reg <= en_reg))
        else $error("list or emit count beyond depth");

    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUMMARY && out_ready) |=>
        (state_reg == ST_IDLE && fc_reg == '0 && sc_reg == '0 && !ovf_reg))
        else $error("run did not clear lists");

    a_pair_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAIR_T || state_reg == ST_PAIR_E) |->
        (y_reg >= sj_reg && y_reg < j_reg && x_reg >= si_reg && x_reg < i_reg))
        else $error("pair pointer outside block");

    a_emit_space: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> out_ready)
        else $error("result pushed into full output register");

endmodule
